/* hdl/acd_variance_recursion_defines.svh */
// Assertion macros shared by the level recursion block.
`ifndef ACD_VARIANCE_RECURSION_DEFINES_SVH
`define ACD_VARIANCE_RECURSION_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define ACDVR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ACDVR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/acdvr_pkg.sv */
// Types, constants and arithmetic helpers for the level recursion block.
`default_nettype none

package acdvr_pkg;

  localparam int MAX_SHOCK_ORDER = 2;
  localparam int MAX_LEVEL_ORDER = 2;
  localparam int FRAC_BITS = 24;

  localparam int DATA_W = 32;
  localparam int FULL_W = 2 * DATA_W;
  localparam int PROD_W = FULL_W - FRAC_BITS;
  localparam int ACC_W = PROD_W + 4;

  localparam logic [1:0] SHOCK_LIMIT = 2'((MAX_SHOCK_ORDER > 2) ? 2 : MAX_SHOCK_ORDER);
  localparam logic [1:0] LEVEL_LIMIT = 2'((MAX_LEVEL_ORDER > 2) ? 2 : MAX_LEVEL_ORDER);

  localparam logic [3:0] LAG_ORDERS_RESET = 4'd5;

  typedef enum logic [2:0] {
    REG_LAG_ORDERS = 3'd0,
    REG_OMEGA      = 3'd1,
    REG_ALPHA_LAG1 = 3'd2,
    REG_ALPHA_LAG2 = 3'd3,
    REG_GAMMA_LAG1 = 3'd4,
    REG_GAMMA_LAG2 = 3'd5,
    REG_BETA_LAG1  = 3'd6,
    REG_BETA_LAG2  = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] base_level;
    logic signed [DATA_W-1:0] shock_prev;
    logic signed [DATA_W-1:0] neg_shock_prev;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] level;
    logic                     saturated;
  } rsp_t;

  typedef struct packed {
    logic [3:0]               lag_orders;
    logic signed [DATA_W-1:0] omega;
    logic signed [DATA_W-1:0] alpha_lag1;
    logic signed [DATA_W-1:0] alpha_lag2;
    logic signed [DATA_W-1:0] gamma_lag1;
    logic signed [DATA_W-1:0] gamma_lag2;
    logic signed [DATA_W-1:0] beta_lag1;
    logic signed [DATA_W-1:0] beta_lag2;
  } cfg_t;

  typedef struct packed {
    logic a_valid;
    logic b_valid;
    logic c_valid;
  } pipe_status_t;

  // Full product shifted down by the fraction width, rounding toward minus infinity.
  function automatic logic signed [PROD_W-1:0] mulq(input logic signed [DATA_W-1:0] a,
                                                    input logic signed [DATA_W-1:0] b);
    logic signed [FULL_W-1:0] prod;
    prod = FULL_W'(a) * FULL_W'(b);
    return $signed(prod[FULL_W-1:FRAC_BITS]);
  endfunction

  function automatic logic [1:0] shock_order(input logic [3:0] lag_orders);
    return (lag_orders[1:0] > SHOCK_LIMIT) ? SHOCK_LIMIT : lag_orders[1:0];
  endfunction

  function automatic logic [1:0] level_order(input logic [3:0] lag_orders);
    return (lag_orders[3:2] > LEVEL_LIMIT) ? LEVEL_LIMIT : lag_orders[3:2];
  endfunction

endpackage

`default_nettype wire

/* hdl/acdvr_cfg_regs.sv */
// Configuration register file of the level recursion block.
`default_nettype none

module acdvr_cfg_regs
  import acdvr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_wr_en,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [DATA_W-1:0] cfg_wdata,
  output cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lag_orders <= LAG_ORDERS_RESET;
      cfg.omega      <= '0;
      cfg.alpha_lag1 <= '0;
      cfg.alpha_lag2 <= '0;
      cfg.gamma_lag1 <= '0;
      cfg.gamma_lag2 <= '0;
      cfg.beta_lag1  <= '0;
      cfg.beta_lag2  <= '0;
    end else if (cfg_wr_en) begin
      unique case (reg_idx_t'(cfg_index))
        REG_LAG_ORDERS: cfg.lag_orders <= cfg_wdata[3:0];
        REG_OMEGA:      cfg.omega      <= $signed(cfg_wdata);
        REG_ALPHA_LAG1: cfg.alpha_lag1 <= $signed(cfg_wdata);
        REG_ALPHA_LAG2: cfg.alpha_lag2 <= $signed(cfg_wdata);
        REG_GAMMA_LAG1: cfg.gamma_lag1 <= $signed(cfg_wdata);
        REG_GAMMA_LAG2: cfg.gamma_lag2 <= $signed(cfg_wdata);
        REG_BETA_LAG1:  cfg.beta_lag1  <= $signed(cfg_wdata);
        REG_BETA_LAG2:  cfg.beta_lag2  <= $signed(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* hdl/acdvr_feedforward.sv */
// Input register, shock products and partial sum stages of the level recursion.
`default_nettype none

module acdvr_feedforward
  import acdvr_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    req_valid,
  output logic                         req_stall,
  input  wire req_t                    req,
  input  wire cfg_t                    cfg,
  input  wire logic                    out_ready,
  output logic                         c_valid,
  output logic signed [ACC_W-1:0]      c_sum,
  output pipe_status_t                 status
);

  logic                     a_valid;
  req_t                     a_req;
  logic signed [DATA_W-1:0] a_shock2;
  logic signed [DATA_W-1:0] a_neg2;
  logic signed [DATA_W-1:0] shock_hist2;
  logic signed [DATA_W-1:0] neg_shock_hist2;

  logic                     b_valid;
  logic signed [ACC_W-1:0]  b_base_omega;
  logic signed [PROD_W-1:0] b_alpha1;
  logic signed [PROD_W-1:0] b_gamma1;
  logic signed [PROD_W-1:0] b_alpha2;
  logic signed [PROD_W-1:0] b_gamma2;

  logic       a_ready;
  logic       b_ready;
  logic       c_ready;
  logic [1:0] q;

  assign c_ready   = !c_valid || out_ready;
  assign b_ready   = !b_valid || c_ready;
  assign a_ready   = !a_valid || b_ready;
  assign req_stall = !a_ready;
  assign q         = shock_order(cfg.lag_orders);

  assign status.a_valid = a_valid;
  assign status.b_valid = b_valid;
  assign status.c_valid = c_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid         <= 1'b0;
      shock_hist2     <= '0;
      neg_shock_hist2 <= '0;
    end else if (a_ready) begin
      a_valid <= req_valid;
      if (req_valid) begin
        shock_hist2     <= req.shock_prev;
        neg_shock_hist2 <= req.neg_shock_prev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_req    <= req;
      a_shock2 <= shock_hist2;
      a_neg2   <= neg_shock_hist2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_ready) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b_ready) begin
      b_base_omega <= ACC_W'(a_req.base_level) + ACC_W'(cfg.omega);
      b_alpha1     <= (q >= 2'd1) ? mulq(cfg.alpha_lag1, a_req.shock_prev) : '0;
      b_gamma1     <= (q >= 2'd1) ? mulq(cfg.gamma_lag1, a_req.neg_shock_prev) : '0;
      b_alpha2     <= (q >= 2'd2) ? mulq(cfg.alpha_lag2, a_shock2) : '0;
      b_gamma2     <= (q >= 2'd2) ? mulq(cfg.gamma_lag2, a_neg2) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (c_ready) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (c_ready) begin
      c_sum <= b_base_omega + ACC_W'(b_alpha1) + ACC_W'(b_gamma1)
             + ACC_W'(b_alpha2) + ACC_W'(b_gamma2);
    end
  end

endmodule

`default_nettype wire

/* hdl/acdvr_feedback.sv */
// Level feedback, saturation and result register of the level recursion.
`default_nettype none

module acdvr_feedback
  import acdvr_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cfg_t               cfg,
  input  wire logic               c_valid,
  input  wire logic signed [ACC_W-1:0] c_sum,
  output logic                    out_ready,
  output logic                    rsp_valid,
  input  wire logic               rsp_stall,
  output rsp_t                    rsp
);

  localparam logic signed [ACC_W-1:0] LVL_MAX = ACC_W'(32'sh7fffffff);
  localparam logic signed [ACC_W-1:0] LVL_MIN = ACC_W'(32'sh80000000);

  logic signed [DATA_W-1:0] level_hist1;
  logic signed [DATA_W-1:0] level_hist2;
  logic signed [PROD_W-1:0] beta2_prod;

  logic                     commit;
  logic [1:0]               p;
  logic signed [PROD_W-1:0] beta1_term;
  logic signed [PROD_W-1:0] beta2_term;
  logic signed [ACC_W-1:0]  total;
  logic signed [DATA_W-1:0] level_next;
  logic                     sat_next;

  assign out_ready = !rsp_valid || !rsp_stall;
  assign commit    = c_valid && out_ready;
  assign p         = level_order(cfg.lag_orders);

  always_comb begin
    beta1_term = (p >= 2'd1) ? mulq(cfg.beta_lag1, level_hist1) : '0;
    beta2_term = (p >= 2'd2) ? beta2_prod : '0;
    total      = c_sum + ACC_W'(beta1_term) + ACC_W'(beta2_term);
    if (total > LVL_MAX) begin
      level_next = LVL_MAX[DATA_W-1:0];
      sat_next   = 1'b1;
    end else if (total < LVL_MIN) begin
      level_next = LVL_MIN[DATA_W-1:0];
      sat_next   = 1'b1;
    end else begin
      level_next = total[DATA_W-1:0];
      sat_next   = 1'b0;
    end
  end

  // The lag-two product is formed one step ahead from the level that is about to age.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid   <= 1'b0;
      level_hist1 <= '0;
      level_hist2 <= '0;
      beta2_prod  <= '0;
    end else begin
      if (out_ready) begin
        rsp_valid <= c_valid;
      end
      if (commit) begin
        level_hist1 <= level_next;
        level_hist2 <= level_hist1;
        beta2_prod  <= mulq(cfg.beta_lag2, level_hist1);
      end else begin
        beta2_prod  <= mulq(cfg.beta_lag2, level_hist2);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      rsp.level     <= level_next;
      rsp.saturated <= sat_next;
    end
  end

endmodule

`default_nettype wire

/* hdl/acd_variance_recursion.sv */
// Top level of the streaming GJR-style level recursion block.
//
// Requests arrive on req with req_valid and are taken at a clock edge where
// req_stall is low. Each request yields exactly one result on rsp, offered with
// rsp_valid and taken at an edge where rsp_stall is low.
// Each request passes the input, product, partial sum and result registers.
// One request is accepted every cycle while the result side keeps up; the
// level feedback path (lag-one weight times the previous level, sum and clip)
// is combinational into the result register, which sets that rate.
// Four pipeline registers hold requests in flight, so a stalled result does
// not stop new requests until all stages are full; req_stall then follows.
// Configuration is written through cfg_wr_en, cfg_index and cfg_wdata while no
// request is in flight and takes effect for the next request.
// Synchronous reset empties the pipeline, clears the shock and level history
// to zero, sets the lag orders to one each and all weights to zero.
`default_nettype none
`include "acd_variance_recursion_defines.svh"

module acd_variance_recursion
  import acdvr_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_stall,
  input  wire req_t              req,
  output logic                   rsp_valid,
  input  wire logic              rsp_stall,
  output rsp_t                   rsp,
  input  wire logic              cfg_wr_en,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [DATA_W-1:0] cfg_wdata
);

  cfg_t                    cfg;
  logic                    out_ready;
  logic                    c_valid;
  logic signed [ACC_W-1:0] c_sum;
  pipe_status_t            status;

  acdvr_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  acdvr_feedforward u_feedforward (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .cfg       (cfg),
    .out_ready (out_ready),
    .c_valid   (c_valid),
    .c_sum     (c_sum),
    .status    (status)
  );

  acdvr_feedback u_feedback (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .c_valid   (c_valid),
    .c_sum     (c_sum),
    .out_ready (out_ready),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  `ACDVR_ASSERT_SAME(a_sat_at_limit, rsp_valid && rsp.saturated,
    (rsp.level == 32'sh7fffffff) || (rsp.level == 32'sh80000000),
    "Saturated result is not at a range limit.")
  `ACDVR_ASSERT_SAME(a_stall_only_when_full, req_stall,
    status.a_valid && status.b_valid && status.c_valid && rsp_valid && rsp_stall,
    "Request stalled while the pipeline has room.")
  `ACDVR_ASSERT_NEXT(a_sum_reaches_output, status.c_valid && out_ready,
    rsp_valid,
    "Partial sum advanced without producing a result.")

endmodule

`default_nettype wire

/* sim/testbench.sv */
// Self-checking testbench for the streaming GJR-style level recursion block.
`timescale 1ns / 100ps

module testbench;
  import acdvr_pkg::*;

  localparam int SHOCK_CAP = (MAX_SHOCK_ORDER > 2) ? 2 : MAX_SHOCK_ORDER;
  localparam int LEVEL_CAP = (MAX_LEVEL_ORDER > 2) ? 2 : MAX_LEVEL_ORDER;
  localparam longint LEVEL_MAX = 64'sd2147483647;
  localparam longint LEVEL_MIN = -64'sd2147483648;
  localparam logic [31:0] ONE_Q = 32'h0100_0000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic cfg_wr_en = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_wdata = '0;

  acd_variance_recursion dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  req_t pending_reqs[$];
  rsp_t level_expect[$];
  int errors = 0;
  bit req_fired = 1'b0;
  bit req_idle_on = 1'b1;
  bit rsp_idle_on = 1'b1;
  int req_gap = 0;
  int stall_left = 0;

  // Shadow of the register file and of the recursion history.
  cfg_t model_cfg;
  logic signed [31:0] shock_d2, neg_d2, level_d1, level_d2;

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic longint scaled(logic signed [31:0] w, logic signed [31:0] x);
    longint prod;
    prod = longint'(w) * longint'(x);
    return prod >>> FRAC_BITS;
  endfunction

  function automatic logic [31:0] rand_word();
    logic [31:0] corners[5];
    corners = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1, 32'hFFFF_FFFF};
    case ($urandom_range(0, 5))
      0: return corners[$urandom_range(0, 4)];
      1, 2: return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic predict_level(input req_t r);
    longint acc;
    int q, p;
    rsp_t want;
    q = (model_cfg.lag_orders[1:0] > SHOCK_CAP) ? SHOCK_CAP : model_cfg.lag_orders[1:0];
    p = (model_cfg.lag_orders[3:2] > LEVEL_CAP) ? LEVEL_CAP : model_cfg.lag_orders[3:2];
    acc = longint'(r.base_level) + longint'(model_cfg.omega);
    if (q >= 1) begin
      acc += scaled(model_cfg.alpha_lag1, r.shock_prev);
      acc += scaled(model_cfg.gamma_lag1, r.neg_shock_prev);
    end
    if (q >= 2) begin
      acc += scaled(model_cfg.alpha_lag2, shock_d2);
      acc += scaled(model_cfg.gamma_lag2, neg_d2);
    end
    if (p >= 1) acc += scaled(model_cfg.beta_lag1, level_d1);
    if (p >= 2) acc += scaled(model_cfg.beta_lag2, level_d2);
    want.saturated = 1'b0;
    if (acc > LEVEL_MAX) begin
      acc = LEVEL_MAX;
      want.saturated = 1'b1;
    end else if (acc < LEVEL_MIN) begin
      acc = LEVEL_MIN;
      want.saturated = 1'b1;
    end
    want.level = acc[31:0];
    shock_d2 = r.shock_prev;
    neg_d2 = r.neg_shock_prev;
    level_d2 = level_d1;
    level_d1 = want.level;
    level_expect.push_back(want);
  endtask

  // Request side driver.
  always @(negedge clk) begin : drive_req
    logic nxt_valid;
    req_t nxt_req;
    int nxt_gap;
    if (!rst) begin
      nxt_valid = req_valid;
      nxt_req = req;
      nxt_gap = req_gap;
      if (req_valid && req_fired) nxt_valid = 1'b0;
      if (!nxt_valid) begin
        if (nxt_gap > 0) begin
          nxt_gap--;
        end else if (pending_reqs.size() > 0) begin
          nxt_req = pending_reqs.pop_front();
          nxt_valid = 1'b1;
          nxt_gap = req_idle_on ? pick_gap() : 0;
        end
      end
      req_valid <= nxt_valid;
      req <= nxt_req;
      req_gap <= nxt_gap;
    end
  end

  // Result side back-pressure.
  always @(negedge clk) begin : drive_stall
    if (!rst) begin
      if (stall_left > 0) begin
        rsp_stall <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
        rsp_stall <= 1'b1;
        stall_left <= pick_gap();
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // Accepted requests feed the predictor; accepted results are checked.
  always @(posedge clk) begin : watch
    rsp_t want;
    req_fired = !rst && req_valid && !req_stall;
    if (req_fired) predict_level(req);
    if (!rst && rsp_valid && !rsp_stall) begin
      if (level_expect.size() == 0) begin
        errors++;
        $display("%0t: unexpected result level=%h saturated=%b", $time, rsp.level,
                 rsp.saturated);
      end else begin
        want = level_expect.pop_front();
        if (rsp.level !== want.level) begin
          errors++;
          $display("%0t: level mismatch expected=%h actual=%h", $time, want.level,
                   rsp.level);
        end
        if (rsp.saturated !== want.saturated) begin
          errors++;
          $display("%0t: saturated mismatch expected=%b actual=%b", $time,
                   want.saturated, rsp.saturated);
        end
      end
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_LAG_ORDERS: model_cfg.lag_orders = val[3:0];
      REG_OMEGA:      model_cfg.omega = val;
      REG_ALPHA_LAG1: model_cfg.alpha_lag1 = val;
      REG_ALPHA_LAG2: model_cfg.alpha_lag2 = val;
      REG_GAMMA_LAG1: model_cfg.gamma_lag1 = val;
      REG_GAMMA_LAG2: model_cfg.gamma_lag2 = val;
      REG_BETA_LAG1:  model_cfg.beta_lag1 = val;
      REG_BETA_LAG2:  model_cfg.beta_lag2 = val;
      default: ;
    endcase
  endtask

  task automatic load_setup(input logic [3:0] orders, input logic [31:0] w[7]);
    write_reg(REG_LAG_ORDERS, {28'h0, orders});
    write_reg(REG_OMEGA, w[0]);
    write_reg(REG_ALPHA_LAG1, w[1]);
    write_reg(REG_ALPHA_LAG2, w[2]);
    write_reg(REG_GAMMA_LAG1, w[3]);
    write_reg(REG_GAMMA_LAG2, w[4]);
    write_reg(REG_BETA_LAG1, w[5]);
    write_reg(REG_BETA_LAG2, w[6]);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (pending_reqs.size() > 0 || req_valid || level_expect.size() > 0);
    repeat (6) @(negedge clk);
  endtask

  task automatic push_req(input logic [31:0] b, input logic [31:0] s, input logic [31:0] n);
    req_t r;
    r.base_level = b;
    r.shock_prev = s;
    r.neg_shock_prev = n;
    pending_reqs.push_back(r);
  endtask

  task automatic random_setup();
    logic [31:0] w[7];
    bit plausible;
    plausible = $urandom_range(0, 2) != 0;
    for (int i = 0; i < 7; i++) w[i] = rand_word();
    if (plausible) begin
      w[0] = $urandom_range(0, ONE_Q / 8);
      w[1] = $urandom_range(0, ONE_Q / 4);
      w[2] = $urandom_range(0, ONE_Q / 8);
      w[3] = $urandom_range(0, ONE_Q / 4);
      w[4] = $urandom_range(0, ONE_Q / 8);
      w[5] = $urandom_range(0, ONE_Q * 3 / 4);
      w[6] = $urandom_range(0, ONE_Q / 8);
    end
    // Zero asymmetric weights give the symmetric recursion.
    if ($urandom_range(0, 3) == 0) begin
      w[3] = '0;
      w[4] = '0;
    end
    req_idle_on = $urandom_range(0, 3) != 0;
    rsp_idle_on = $urandom_range(0, 3) != 0;
    load_setup(4'($urandom_range(0, 15)), w);
  endtask

  task automatic random_items(input int count);
    logic signed [31:0] b, s, n;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 9) < 7) begin
        b = $urandom_range(0, ONE_Q);
        s = $urandom_range(0, 4 * ONE_Q) - 2 * ONE_Q;
        n = (s < 0) ? 32'($urandom_range(0, 2 * ONE_Q)) : 32'h0;
      end else begin
        b = rand_word();
        s = rand_word();
        n = rand_word();
      end
      push_req(b, s, n);
    end
  endtask

  initial begin
    logic [31:0] w[7];
    model_cfg = '0;
    model_cfg.lag_orders = 4'd5;
    shock_d2 = '0;
    neg_d2 = '0;
    level_d1 = '0;
    level_d2 = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // With all weights zero after reset the base level passes straight through.
    push_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_req(32'h0, 32'h0, 32'h0);
    push_req(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    wait_idle();

    // Full second-order recursion with ordinary weights.
    w = '{32'h0010_0000, 32'h0080_0000, 32'hFFC0_0000, ONE_Q, 32'h0040_0000,
          32'h00E0_0000, 32'hFFE0_0000};
    load_setup(4'b1010, w);
    push_req(ONE_Q, 32'h0080_0000, 32'h0);
    push_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    // Products of negative sign round toward minus infinity.
    push_req(32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(32'h0, 32'h0, 32'h0);
    wait_idle();

    // Orders above the limit clamp, weights and constant at their extremes.
    w = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
          32'h7FFF_FFFF, 32'h8000_0000};
    load_setup(4'hF, w);
    push_req(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    push_req(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    push_req(32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF);
    push_req(32'h0, 32'h0, 32'h0);
    wait_idle();

    // Order zero on both sides leaves only the base level and the constant.
    w = '{32'h7FFF_FFFF, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q, ONE_Q};
    load_setup(4'b0000, w);
    push_req(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_req(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    push_req(32'h0000_0001, 32'h0, 32'h0);
    wait_idle();

    for (int ph = 0; ph < 11; ph++) begin
      random_setup();
      random_items(55);
      wait_idle();
    end

    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/acdvr_pkg.sv
hdl/acdvr_cfg_regs.sv
hdl/acdvr_feedforward.sv
hdl/acdvr_feedback.sv
hdl/acd_variance_recursion.sv
sim/testbench.sv
